@@ rtl/core/bsg_pkg.sv @@
`default_nettype none

package bsg_pkg;

   // Fixed field widths of the result and configuration.
   localparam int POS_BITS       = 32;
   localparam int WRAP_BITS      = 23;
   localparam int ADJUST_BITS    = 20;
   localparam int CSR_DATA_BITS  = WRAP_BITS;
   localparam int CSR_INDEX_BITS = 1;
   localparam int QUEUE_DEPTH    = 2;
   localparam int DIV_STEPS      = POS_BITS;

   typedef logic [1:0] cmd_type;
   localparam cmd_type CMD_TICK = 2'd0;
   localparam cmd_type CMD_LOAD = 2'd1;
   localparam cmd_type CMD_STOP = 2'd2;

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   localparam csr_index_type CSR_THETA_WRAP = 1'd0;
   localparam csr_index_type CSR_RHO_ADJUST = 1'd1;

   localparam logic [WRAP_BITS-1:0]   THETA_WRAP_RESET = 23'd16000;
   localparam logic [ADJUST_BITS-1:0] RHO_ADJUST_RESET = 20'd3200;

   // Item class as decided by the front end.
   typedef enum logic [1:0] {
      KIND_TICK,
      KIND_LOAD,
      KIND_STOP,
      KIND_NONE
   } kind_type;

endpackage

`default_nettype wire

@@ rtl/core/bsg_if.sv @@
`default_nettype none

interface bsg_req_if #(parameter int MOVE_BITS = 24);
   logic                        valid;
   logic                        ready;
   bsg_pkg::cmd_type            command;
   logic signed [MOVE_BITS-1:0] theta_move_steps;
   logic signed [MOVE_BITS-1:0] rho_move_steps;

   modport source (output valid, command, theta_move_steps, rho_move_steps, input ready);
   modport sink (input valid, command, theta_move_steps, rho_move_steps, output ready);
endinterface

interface bsg_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                theta_step;
   logic                                rho_step;
   logic                                theta_forward;
   logic                                rho_forward;
   logic                                motion_done;
   logic                                busy_res;
   logic                                load_rejected;
   logic signed [bsg_pkg::POS_BITS-1:0] theta_position;
   logic signed [bsg_pkg::POS_BITS-1:0] rho_position;

   modport source (output valid, theta_step, rho_step, theta_forward, rho_forward,
                   motion_done, busy_res, load_rejected, theta_position, rho_position,
                   input ready);
   modport sink (input valid, theta_step, rho_step, theta_forward, rho_forward,
                 motion_done, busy_res, load_rejected, theta_position, rho_position,
                 output ready);
endinterface

`default_nettype wire

@@ rtl/core/bsg_front.sv @@
`default_nettype none

module bsg_front #(
   parameter int MOVE_BITS = 24
) (
   bsg_req_if.sink                 req_chan,
   output logic                    entry_valid,
   input  logic                    entry_ready,
   output logic [2*MOVE_BITS+4:0]  entry_data
);
   import bsg_pkg::*;

   kind_type               kind;
   logic                   theta_fwd;
   logic                   rho_fwd;
   logic                   theta_ge_rho;
   logic [MOVE_BITS-1:0]   theta_mag;
   logic [MOVE_BITS-1:0]   rho_mag;

   always_comb begin
      unique case (req_chan.command)
         CMD_TICK: kind = KIND_TICK;
         CMD_LOAD: kind = KIND_LOAD;
         CMD_STOP: kind = KIND_STOP;
         default:  kind = KIND_NONE;
      endcase
   end

   // Magnitudes are taken as unsigned so that the most negative count keeps its value.
   assign theta_fwd    = ~req_chan.theta_move_steps[MOVE_BITS-1];
   assign rho_fwd      = ~req_chan.rho_move_steps[MOVE_BITS-1];
   assign theta_mag    = theta_fwd ? req_chan.theta_move_steps : -req_chan.theta_move_steps;
   assign rho_mag      = rho_fwd ? req_chan.rho_move_steps : -req_chan.rho_move_steps;
   assign theta_ge_rho = theta_mag >= rho_mag;

   assign entry_data   = {kind, theta_fwd, rho_fwd, theta_ge_rho, theta_mag, rho_mag};
   assign entry_valid  = req_chan.valid;
   assign req_chan.ready = entry_ready;

endmodule

`default_nettype wire

@@ rtl/core/bsg_queue.sv @@
`default_nettype none

module bsg_queue #(
   parameter int WIDTH = 53,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0]   PTR_LAST  = PTR_BITS'(DEPTH - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = COUNT_BITS'(DEPTH);

   logic [WIDTH-1:0]      slots_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  push;
   logic                  pop;

   assign in_ready  = count_ff != COUNT_MAX;
   assign out_valid = count_ff != '0;
   assign out_data  = slots_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= in_data;
      end
   end

`ifndef SYNTHESIS
   a_count_tracks_push : assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue fill count did not follow a lone push");
`endif

endmodule

`default_nettype wire

@@ rtl/core/bsg_wrap_div.sv @@
`default_nettype none

module bsg_wrap_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [bsg_pkg::POS_BITS-1:0]    dividend,
   input  logic [bsg_pkg::WRAP_BITS-1:0]   divisor,
   input  logic [bsg_pkg::ADJUST_BITS-1:0] factor,
   output logic                          done,
   output logic [bsg_pkg::WRAP_BITS-1:0]   remainder,
   output logic [bsg_pkg::POS_BITS-1:0]    product
);
   import bsg_pkg::*;

   localparam int COUNT_BITS = $clog2(DIV_STEPS);
   localparam logic [COUNT_BITS-1:0] COUNT_LAST = COUNT_BITS'(DIV_STEPS - 1);

   logic                    run_ff, run_in;
   logic                    done_ff, done_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic [POS_BITS-1:0]     dividend_ff, dividend_in;
   logic [WRAP_BITS-1:0]    rem_ff, rem_in;
   logic [POS_BITS-1:0]     prod_ff, prod_in;
   logic [WRAP_BITS:0]      trial;
   logic [WRAP_BITS:0]      diff;
   logic                    fits;
   logic [WRAP_BITS-1:0]    rem_next;
   logic [POS_BITS-1:0]     prod_next;

   // Restoring division, one quotient bit per cycle. The quotient times the rho
   // factor is accumulated Horner style, so only its low word is ever formed.
   assign trial     = {rem_ff, dividend_ff[POS_BITS-1]};
   assign fits      = trial >= {1'b0, divisor};
   assign diff      = trial - {1'b0, divisor};
   assign rem_next  = fits ? diff[WRAP_BITS-1:0] : trial[WRAP_BITS-1:0];
   assign prod_next = {prod_ff[POS_BITS-2:0], 1'b0} + (fits ? POS_BITS'(factor) : '0);

   always_comb begin
      run_in      = run_ff;
      done_in     = 1'b0;
      count_in    = count_ff;
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      prod_in     = prod_ff;
      if (start) begin
         run_in      = 1'b1;
         count_in    = '0;
         dividend_in = dividend;
         rem_in      = '0;
         prod_in     = '0;
      end else if (run_ff) begin
         dividend_in = {dividend_ff[POS_BITS-2:0], 1'b0};
         rem_in      = rem_next;
         prod_in     = prod_next;
         count_in    = count_ff + 1'b1;
         if (count_ff == COUNT_LAST) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff      <= 1'b0;
         done_ff     <= 1'b0;
         count_ff    <= '0;
         dividend_ff <= '0;
         rem_ff      <= '0;
         prod_ff     <= '0;
      end else begin
         run_ff      <= run_in;
         done_ff     <= done_in;
         count_ff    <= count_in;
         dividend_ff <= dividend_in;
         rem_ff      <= rem_in;
         prod_ff     <= prod_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
   assign product   = prod_ff;

`ifndef SYNTHESIS
   a_no_restart : assert property (@(posedge clock) disable iff (reset)
      start |-> !run_ff)
      else $error("divider started while a division was running");
`endif

endmodule

`default_nettype wire

@@ rtl/core/bsg_back.sv @@
`default_nettype none

module bsg_back #(
   parameter int MOVE_BITS = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            entry_valid,
   output logic                            entry_ready,
   input  logic [2*MOVE_BITS+4:0]          entry_data,
   input  logic                            csr_write_enable,
   input  bsg_pkg::csr_index_type          csr_index,
   input  logic [bsg_pkg::CSR_DATA_BITS-1:0] csr_write_data,
   output logic                            div_start,
   output logic [bsg_pkg::POS_BITS-1:0]    div_dividend,
   output logic [bsg_pkg::WRAP_BITS-1:0]   div_divisor,
   output logic [bsg_pkg::ADJUST_BITS-1:0] div_factor,
   input  logic                            div_done,
   input  logic [bsg_pkg::WRAP_BITS-1:0]   div_remainder,
   input  logic [bsg_pkg::POS_BITS-1:0]    div_product,
   bsg_rsp_if.source                       rsp_chan
);
   import bsg_pkg::*;

   localparam int ERR_BITS  = MOVE_BITS + 1;
   localparam int WIDE_BITS = MOVE_BITS + 2;
   localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type                   state_ff, state_in;
   logic [WRAP_BITS-1:0]        theta_wrap_ff, theta_wrap_in;
   logic [ADJUST_BITS-1:0]      rho_adjust_ff, rho_adjust_in;
   logic [MOVE_BITS-1:0]        theta_rem_ff, theta_rem_in;
   logic [MOVE_BITS-1:0]        rho_rem_ff, rho_rem_in;
   logic signed [ERR_BITS-1:0]  err_ff, err_in;
   logic                        theta_fwd_ff, theta_fwd_in;
   logic                        rho_fwd_ff, rho_fwd_in;
   logic                        active_ff, active_in;
   logic [POS_BITS-1:0]         theta_pos_ff, theta_pos_in;
   logic [POS_BITS-1:0]         rho_pos_ff, rho_pos_in;
   logic [MOVE_BITS-1:0]        ld_theta_mag_ff, ld_theta_mag_in;
   logic [MOVE_BITS-1:0]        ld_rho_mag_ff, ld_rho_mag_in;
   logic                        ld_theta_fwd_ff, ld_theta_fwd_in;
   logic                        ld_rho_fwd_ff, ld_rho_fwd_in;
   logic                        ld_ge_ff, ld_ge_in;
   logic                        wrap_up_ff, wrap_up_in;
   logic                        out_valid_ff, out_valid_in;
   logic                        out_theta_step_ff, out_theta_step_in;
   logic                        out_rho_step_ff, out_rho_step_in;
   logic                        out_done_ff, out_done_in;
   logic                        out_rejected_ff, out_rejected_in;

   kind_type                    kind;
   logic                        e_theta_fwd;
   logic                        e_rho_fwd;
   logic                        e_ge;
   logic [MOVE_BITS-1:0]        e_theta_mag;
   logic [MOVE_BITS-1:0]        e_rho_mag;
   logic                        out_free;
   logic                        take;
   logic                        wrap_up;

   logic signed [WIDE_BITS-1:0] e_ext;
   logic signed [WIDE_BITS-1:0] t_ext;
   logic signed [WIDE_BITS-1:0] r_ext;
   logic signed [WIDE_BITS-1:0] e_first;
   logic signed [WIDE_BITS-1:0] e_final;
   logic                        st_raw;
   logic                        sr_raw;
   logic                        st_eff;
   logic                        sr_eff;
   logic [MOVE_BITS-1:0]        theta_rem_next;
   logic [MOVE_BITS-1:0]        rho_rem_next;

   assign kind        = kind_type'(entry_data[2*MOVE_BITS+4 -: 2]);
   assign e_theta_fwd = entry_data[2*MOVE_BITS+2];
   assign e_rho_fwd   = entry_data[2*MOVE_BITS+1];
   assign e_ge        = entry_data[2*MOVE_BITS];
   assign e_theta_mag = entry_data[2*MOVE_BITS-1 -: MOVE_BITS];
   assign e_rho_mag   = entry_data[MOVE_BITS-1:0];

   // The result register is free when empty or when its transfer completes now.
   assign out_free    = !out_valid_ff || rsp_chan.ready;
   assign entry_ready = (state_ff == ST_IDLE) && out_free;
   assign take        = entry_valid && entry_ready;

   // Positive theta wraps on (theta - 1) / rotation, zero or negative on -theta / rotation.
   assign wrap_up      = !theta_pos_ff[POS_BITS-1] && (theta_pos_ff != '0);
   assign div_dividend = wrap_up ? theta_pos_ff - POS_ONE : '0 - theta_pos_ff;
   assign div_divisor  = theta_wrap_ff;
   assign div_factor   = rho_adjust_ff;
   assign div_start    = take && (kind == KIND_LOAD) && !active_ff && (theta_wrap_ff != '0);

   // One Bresenham update. The primary axis follows the counts remaining now.
   always_comb begin
      e_ext   = {err_ff[ERR_BITS-1], err_ff};
      t_ext   = {2'b00, theta_rem_ff};
      r_ext   = {2'b00, rho_rem_ff};
      st_raw  = 1'b0;
      sr_raw  = 1'b0;
      if (theta_rem_ff >= rho_rem_ff) begin
         e_first = e_ext - r_ext;
         e_final = e_first;
         if (e_first[WIDE_BITS-1]) begin
            e_final = e_first + t_ext;
            sr_raw  = 1'b1;
         end
         st_raw = theta_rem_ff != '0;
      end else begin
         e_first = e_ext + t_ext;
         e_final = e_first;
         if (!e_first[WIDE_BITS-1] && (e_first != '0)) begin
            e_final = e_first - r_ext;
            st_raw  = 1'b1;
         end
         sr_raw = rho_rem_ff != '0;
      end
      st_eff         = st_raw && (theta_rem_ff != '0);
      sr_eff         = sr_raw && (rho_rem_ff != '0);
      theta_rem_next = theta_rem_ff - MOVE_BITS'(st_eff);
      rho_rem_next   = rho_rem_ff - MOVE_BITS'(sr_eff);
   end

   always_comb begin
      state_in          = state_ff;
      theta_wrap_in     = theta_wrap_ff;
      rho_adjust_in     = rho_adjust_ff;
      theta_rem_in      = theta_rem_ff;
      rho_rem_in        = rho_rem_ff;
      err_in            = err_ff;
      theta_fwd_in      = theta_fwd_ff;
      rho_fwd_in        = rho_fwd_ff;
      active_in         = active_ff;
      theta_pos_in      = theta_pos_ff;
      rho_pos_in        = rho_pos_ff;
      ld_theta_mag_in   = ld_theta_mag_ff;
      ld_rho_mag_in     = ld_rho_mag_ff;
      ld_theta_fwd_in   = ld_theta_fwd_ff;
      ld_rho_fwd_in     = ld_rho_fwd_ff;
      ld_ge_in          = ld_ge_ff;
      wrap_up_in        = wrap_up_ff;
      out_valid_in      = out_valid_ff && !rsp_chan.ready;
      out_theta_step_in = out_theta_step_ff;
      out_rho_step_in   = out_rho_step_ff;
      out_done_in       = out_done_ff;
      out_rejected_in   = out_rejected_ff;

      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_THETA_WRAP: theta_wrap_in = csr_write_data;
            CSR_RHO_ADJUST: rho_adjust_in = csr_write_data[ADJUST_BITS-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               out_theta_step_in = 1'b0;
               out_rho_step_in   = 1'b0;
               out_done_in       = 1'b0;
               out_rejected_in   = 1'b0;
               unique case (kind)
                  KIND_TICK: begin
                     out_valid_in = 1'b1;
                     if (active_ff) begin
                        err_in            = e_final[ERR_BITS-1:0];
                        theta_rem_in      = theta_rem_next;
                        rho_rem_in        = rho_rem_next;
                        out_theta_step_in = st_eff;
                        out_rho_step_in   = sr_eff;
                        if (st_eff) begin
                           theta_pos_in = theta_pos_ff + (theta_fwd_ff ? POS_ONE : '1);
                        end
                        if (sr_eff) begin
                           rho_pos_in = rho_pos_ff + (rho_fwd_ff ? POS_ONE : '1);
                        end
                        if ((theta_rem_next == '0) && (rho_rem_next == '0)) begin
                           active_in   = 1'b0;
                           out_done_in = 1'b1;
                        end
                     end
                  end
                  KIND_STOP: begin
                     out_valid_in = 1'b1;
                     theta_rem_in = '0;
                     rho_rem_in   = '0;
                     err_in       = '0;
                     active_in    = 1'b0;
                  end
                  KIND_LOAD: begin
                     if (active_ff) begin
                        out_valid_in    = 1'b1;
                        out_rejected_in = 1'b1;
                     end else begin
                        ld_theta_mag_in = e_theta_mag;
                        ld_rho_mag_in   = e_rho_mag;
                        ld_theta_fwd_in = e_theta_fwd;
                        ld_rho_fwd_in   = e_rho_fwd;
                        ld_ge_in        = e_ge;
                        wrap_up_in      = wrap_up;
                        state_in        = (theta_wrap_ff != '0) ? ST_DIVIDE : ST_FINISH;
                     end
                  end
                  default: begin
                     out_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               if (wrap_up_ff) begin
                  theta_pos_in = POS_BITS'(div_remainder) + POS_ONE;
                  rho_pos_in   = rho_pos_ff - div_product;
               end else begin
                  theta_pos_in = '0 - POS_BITS'(div_remainder);
                  rho_pos_in   = rho_pos_ff + div_product;
               end
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               theta_fwd_in = ld_theta_fwd_ff;
               rho_fwd_in   = ld_rho_fwd_ff;
               theta_rem_in = ld_theta_mag_ff;
               rho_rem_in   = ld_rho_mag_ff;
               err_in       = ld_ge_ff ? {2'b00, ld_theta_mag_ff[MOVE_BITS-1:1]}
                                       : -{2'b00, ld_rho_mag_ff[MOVE_BITS-1:1]};
               active_in    = (ld_theta_mag_ff != '0) || (ld_rho_mag_ff != '0);
               out_valid_in      = 1'b1;
               out_theta_step_in = 1'b0;
               out_rho_step_in   = 1'b0;
               out_rejected_in   = 1'b0;
               out_done_in       = (ld_theta_mag_ff == '0) && (ld_rho_mag_ff == '0);
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         theta_wrap_ff     <= THETA_WRAP_RESET;
         rho_adjust_ff     <= RHO_ADJUST_RESET;
         theta_rem_ff      <= '0;
         rho_rem_ff        <= '0;
         err_ff            <= '0;
         theta_fwd_ff      <= 1'b1;
         rho_fwd_ff        <= 1'b1;
         active_ff         <= 1'b0;
         theta_pos_ff      <= '0;
         rho_pos_ff        <= '0;
         ld_theta_mag_ff   <= '0;
         ld_rho_mag_ff     <= '0;
         ld_theta_fwd_ff   <= 1'b1;
         ld_rho_fwd_ff     <= 1'b1;
         ld_ge_ff          <= 1'b1;
         wrap_up_ff        <= 1'b0;
         out_valid_ff      <= 1'b0;
         out_theta_step_ff <= 1'b0;
         out_rho_step_ff   <= 1'b0;
         out_done_ff       <= 1'b0;
         out_rejected_ff   <= 1'b0;
      end else begin
         state_ff          <= state_in;
         theta_wrap_ff     <= theta_wrap_in;
         rho_adjust_ff     <= rho_adjust_in;
         theta_rem_ff      <= theta_rem_in;
         rho_rem_ff        <= rho_rem_in;
         err_ff            <= err_in;
         theta_fwd_ff      <= theta_fwd_in;
         rho_fwd_ff        <= rho_fwd_in;
         active_ff         <= active_in;
         theta_pos_ff      <= theta_pos_in;
         rho_pos_ff        <= rho_pos_in;
         ld_theta_mag_ff   <= ld_theta_mag_in;
         ld_rho_mag_ff     <= ld_rho_mag_in;
         ld_theta_fwd_ff   <= ld_theta_fwd_in;
         ld_rho_fwd_ff     <= ld_rho_fwd_in;
         ld_ge_ff          <= ld_ge_in;
         wrap_up_ff        <= wrap_up_in;
         out_valid_ff      <= out_valid_in;
         out_theta_step_ff <= out_theta_step_in;
         out_rho_step_ff   <= out_rho_step_in;
         out_done_ff       <= out_done_in;
         out_rejected_ff   <= out_rejected_in;
      end
   end

   // Direction, busy and position fields come straight from the state, which
   // only moves when a new result is written or while no result is pending.
   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.theta_step     = out_theta_step_ff;
   assign rsp_chan.rho_step       = out_rho_step_ff;
   assign rsp_chan.theta_forward  = theta_fwd_ff;
   assign rsp_chan.rho_forward    = rho_fwd_ff;
   assign rsp_chan.motion_done    = out_done_ff;
   assign rsp_chan.busy_res       = active_ff;
   assign rsp_chan.load_rejected  = out_rejected_ff;
   assign rsp_chan.theta_position = theta_pos_ff;
   assign rsp_chan.rho_position   = rho_pos_ff;

`ifndef SYNTHESIS
   a_idle_during_load : assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !active_ff)
      else $error("motion active while a load is being prepared");
   a_no_pending_result_in_wrap : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> !out_valid_ff)
      else $error("result pending while the position wrap runs");
   a_active_matches_counts : assert property (@(posedge clock) disable iff (reset)
      active_ff == ((theta_rem_ff != '0) || (rho_rem_ff != '0)))
      else $error("motion flag disagrees with the remaining counts");
`endif

endmodule

`default_nettype wire

@@ rtl/core/two_axis_bresenham_step_generator.sv @@
`default_nettype none

// Channel    Direction  Handshake         Payload
// req_chan   in         valid / ready     command, theta_move_steps, rho_move_steps
// rsp_chan   out        valid / ready     step, direction, done, busy, reject, positions
// csr        in         csr_write_enable  csr_index, csr_write_data
//
// Every item gives one result. A tick, stop, rejected load or unknown command
// is handled in the idle state of the execution unit, so transfers can follow
// back to back. An accepted load passes through the 32-step restoring divider,
// which folds theta into one rotation, only when wrapping is on.
// Reset is synchronous and active high; all state is ready the cycle after.
// A two-entry queue between classifier and execution unit absorbs input while
// results stall, and the result register frees as its transfer completes.
module two_axis_bresenham_step_generator #(
   parameter int MOVE_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   bsg_req_if.sink                           req_chan,
   bsg_rsp_if.source                         rsp_chan,
   input  logic                              csr_write_enable,
   input  bsg_pkg::csr_index_type            csr_index,
   input  logic [bsg_pkg::CSR_DATA_BITS-1:0] csr_write_data
);
   import bsg_pkg::*;

   localparam int ENTRY_BITS = 2 * MOVE_BITS + 5;

   logic                    front_valid;
   logic                    front_ready;
   logic [ENTRY_BITS-1:0]   front_data;
   logic                    queue_valid;
   logic                    queue_ready;
   logic [ENTRY_BITS-1:0]   queue_data;
   logic                    div_start;
   logic [POS_BITS-1:0]     div_dividend;
   logic [WRAP_BITS-1:0]    div_divisor;
   logic [ADJUST_BITS-1:0]  div_factor;
   logic                    div_done;
   logic [WRAP_BITS-1:0]    div_remainder;
   logic [POS_BITS-1:0]     div_product;

   bsg_front #(.MOVE_BITS(MOVE_BITS)) u_front (
      .req_chan    (req_chan),
      .entry_valid (front_valid),
      .entry_ready (front_ready),
      .entry_data  (front_data)
   );

   bsg_queue #(.WIDTH(ENTRY_BITS), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_data  (queue_data)
   );

   bsg_wrap_div u_wrap_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .factor    (div_factor),
      .done      (div_done),
      .remainder (div_remainder),
      .product   (div_product)
   );

   bsg_back #(.MOVE_BITS(MOVE_BITS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .entry_valid      (queue_valid),
      .entry_ready      (queue_ready),
      .entry_data       (queue_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .div_start        (div_start),
      .div_dividend     (div_dividend),
      .div_divisor      (div_divisor),
      .div_factor       (div_factor),
      .div_done         (div_done),
      .div_remainder    (div_remainder),
      .div_product      (div_product),
      .rsp_chan         (rsp_chan)
   );

endmodule

`default_nettype wire
